/* rtl/core/agas_pkg.sv */
// Shared types and constants of the affine-gap alignment scorer.
// Used by agas_cell and affine_gap_alignment_scorer_top; depends on nothing.
package agas_pkg;

   // Command beat: load a read base or stream a genome base.
   typedef struct packed {
      logic       action;
      logic [3:0] base;
      logic       last;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic signed [23:0] best_score;
      logic [6:0]         read_end;
      logic [15:0]        genome_end;
   } rsp_type;

   // Scoring registers as seen by every cell.
   typedef struct packed {
      logic [7:0]        match_score;
      logic signed [8:0] mismatch_score;
      logic [7:0]        west_gap_open;
      logic [7:0]        west_gap_extend;
      logic [7:0]        north_gap_open;
      logic [7:0]        north_gap_extend;
      logic              local_mode;
   } cfg_type;

   // Column being scored, broadcast to the cells during a sweep.
   typedef struct packed {
      logic [3:0] base;
      logic       first;
   } col_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MISMATCH    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEST_OPEN   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEST_EXT    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_NORTH_OPEN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_NORTH_EXT   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCAL_MODE  = 3'd6;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_STREAM = 1'b1;

   localparam cfg_type CFG_RESET = '{
      match_score:      8'd10,
      mismatch_score:   -9'sd15,
      west_gap_open:    8'd40,
      west_gap_extend:  8'd7,
      north_gap_open:   8'd40,
      north_gap_extend: 8'd7,
      local_mode:       1'b1
   };

endpackage

/* rtl/core/agas_cell.sv */
// One read cell of the scoring chain: holds a read base and its three scores.
// Depends on agas_pkg; instantiated in a row by affine_gap_alignment_scorer_top.
module agas_cell import agas_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int READ_CELLS = 128,
   parameter int GENOME_MAX = 65536,
   parameter int SCORE_BITS = 24,
   localparam int LEN_W = $clog2(READ_CELLS + 1),
   localparam int RI_W  = (READ_CELLS > 1) ? $clog2(READ_CELLS) : 1,
   localparam int COL_W = $clog2(GENOME_MAX)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  col_type                      col,
   input  logic [COL_W-1:0]             col_index,
   input  logic [LEN_W-1:0]             read_count,
   input  logic                         load_en,
   input  logic [LEN_W-1:0]             load_index,
   input  logic [3:0]                   load_base,
   input  logic                         in_valid,
   input  logic signed [SCORE_BITS-1:0] in_up_d,
   input  logic signed [SCORE_BITS-1:0] in_up_n,
   input  logic signed [SCORE_BITS-1:0] in_dg_d,
   input  logic signed [SCORE_BITS-1:0] in_dg_n,
   input  logic signed [SCORE_BITS-1:0] in_dg_w,
   input  logic signed [SCORE_BITS-1:0] in_best_val,
   input  logic [RI_W-1:0]              in_best_ri,
   input  logic [COL_W-1:0]             in_best_gi,
   output logic                         out_valid,
   output logic signed [SCORE_BITS-1:0] out_up_d,
   output logic signed [SCORE_BITS-1:0] out_up_n,
   output logic signed [SCORE_BITS-1:0] out_dg_d,
   output logic signed [SCORE_BITS-1:0] out_dg_n,
   output logic signed [SCORE_BITS-1:0] out_dg_w,
   output logic signed [SCORE_BITS-1:0] out_best_val,
   output logic [RI_W-1:0]              out_best_ri,
   output logic [COL_W-1:0]             out_best_gi
);

   localparam int SB = SCORE_BITS;
   localparam int E  = SCORE_BITS + 2;
   localparam longint SAT_HI_L = (longint'(1) << (SCORE_BITS - 1)) - 1;
   localparam longint SAT_LO_L = -(longint'(1) << (SCORE_BITS - 1));
   localparam int     SENT_MAG = (1 << (SCORE_BITS - 2)) - 1;
   localparam logic signed [E-1:0]  SAT_HI   = E'(SAT_HI_L);
   localparam logic signed [E-1:0]  SAT_LO   = E'(SAT_LO_L);
   localparam logic signed [SB-1:0] SENTINEL = SB'(-SENT_MAG);

   function automatic logic signed [E-1:0] sx(input logic signed [SB-1:0] v);
      return $signed({{2{v[SB-1]}}, v});
   endfunction

   function automatic logic signed [E-1:0] zx(input logic [7:0] v);
      return $signed({{(E-8){1'b0}}, v});
   endfunction

   function automatic logic signed [E-1:0] max_e(input logic signed [E-1:0] a,
                                                 input logic signed [E-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [SB-1:0] max_s(input logic signed [SB-1:0] a,
                                                  input logic signed [SB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Saturate, then clamp at zero in local mode.
   function automatic logic signed [SB-1:0] fit(input logic signed [E-1:0] x,
                                                input logic clamp);
      logic signed [SB-1:0] r;
      if (x > SAT_HI) r = SAT_HI[SB-1:0];
      else if (x < SAT_LO) r = SAT_LO[SB-1:0];
      else r = x[SB-1:0];
      if (clamp && (r <= 0)) r = '0;
      return r;
   endfunction

   // Cell state (no reset: always written before it is read back).
   logic [3:0]           base_ff;
   logic signed [SB-1:0] d_ff, n_ff, w_ff;

   logic                 out_valid_ff;
   logic signed [SB-1:0] up_d_ff, up_n_ff, dg_d_ff, dg_n_ff, dg_w_ff, best_val_ff;
   logic [RI_W-1:0]      best_ri_ff;
   logic [COL_W-1:0]     best_gi_ff;

   logic                 active, tail, hit;
   logic signed [SB-1:0] l_d, l_n, l_w, d_in, n_in, w_in, m;
   logic signed [8:0]    ms;
   logic signed [E-1:0]  d_sum, n_sum, w_sum;

   assign active = in_valid && (LEN_W'(INDEX) < read_count);
   assign tail   = (LEN_W'(INDEX + 1) == read_count);

   always_comb begin
      if (col.first) begin
         if (cfg.local_mode) begin
            l_d = '0;
            l_n = SB'(0) - SB'(cfg.north_gap_open);
            l_w = SB'(0) - SB'(cfg.west_gap_open);
         end else begin
            l_d = SENTINEL;
            l_n = SENTINEL;
            l_w = SENTINEL;
         end
      end else begin
         l_d = d_ff;
         l_n = n_ff;
         l_w = w_ff;
      end
      ms    = (base_ff == col.base) ? $signed({1'b0, cfg.match_score}) : cfg.mismatch_score;
      d_sum = sx(max_s(max_s(in_dg_d, in_dg_n), in_dg_w))
              + $signed({{(E-9){ms[8]}}, ms});
      n_sum = max_e(sx(in_up_d) - zx(cfg.north_gap_open) - zx(cfg.north_gap_extend),
                    sx(in_up_n) - zx(cfg.north_gap_extend));
      w_sum = max_e(sx(l_d) - zx(cfg.west_gap_open) - zx(cfg.west_gap_extend),
                    sx(l_w) - zx(cfg.west_gap_extend));
      d_in  = fit(d_sum, cfg.local_mode);
      n_in  = fit(n_sum, cfg.local_mode);
      w_in  = fit(w_sum, cfg.local_mode);
      m     = max_s(max_s(n_in, d_in), w_in);
      // tie goes to the smaller read index; equal column keeps the earlier one
      hit   = (cfg.local_mode || tail) &&
              ((m > in_best_val) || ((m == in_best_val) && (RI_W'(INDEX) < in_best_ri)));
   end

   always_ff @(posedge clock) begin
      if (load_en && (load_index == LEN_W'(INDEX))) begin
         base_ff <= load_base;
      end
      if (active) begin
         d_ff <= d_in;
         n_ff <= n_in;
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         up_d_ff <= d_in;
         up_n_ff <= n_in;
         dg_d_ff <= l_d;
         dg_n_ff <= l_n;
         dg_w_ff <= l_w;
      end else begin
         up_d_ff <= in_up_d;
         up_n_ff <= in_up_n;
         dg_d_ff <= in_dg_d;
         dg_n_ff <= in_dg_n;
         dg_w_ff <= in_dg_w;
      end
      if (active && hit) begin
         best_val_ff <= m;
         best_ri_ff  <= RI_W'(INDEX);
         best_gi_ff  <= col_index;
      end else begin
         best_val_ff <= in_best_val;
         best_ri_ff  <= in_best_ri;
         best_gi_ff  <= in_best_gi;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_up_d     = up_d_ff;
   assign out_up_n     = up_n_ff;
   assign out_dg_d     = dg_d_ff;
   assign out_dg_n     = dg_n_ff;
   assign out_dg_w     = dg_w_ff;
   assign out_best_val = best_val_ff;
   assign out_best_ri  = best_ri_ff;
   assign out_best_gi  = best_gi_ff;

endmodule

/* rtl/core/affine_gap_alignment_scorer_top.sv */
// Top level of the affine-gap alignment scorer: command port, registers,
// window control and the row of agas_cell instances. Depends on agas_pkg.
//
//   channel | ports                                 | dir | beat taken when
//   --------+---------------------------------------+-----+------------------------
//   command | start, busy, req_data                 | in  | start && !busy
//   result  | rsp_valid, rsp_data                   | out | rsp_valid (one cycle)
//   csr     | csr_wr_en, csr_index, csr_wdata       | in  | csr_wr_en
//
// A read-base load does not raise busy. A genome base walks the cell row one cell
// per cycle, so busy stays high from the accept until its token leaves the last cell;
// the chain length sets how long, whatever the loaded read length.
// A genome base past GENOME_MAX is not scored and does not raise busy.
// The result beat shows the cycle after the sweep (or the accept) that ends it.
// Reset is synchronous; no clearing pass. The receiver cannot stall results.
module affine_gap_alignment_scorer_top import agas_pkg::*; #(
   parameter int READ_CELLS = 128,
   parameter int GENOME_MAX = 65536,
   parameter int SCORE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SB    = SCORE_BITS;
   localparam int LEN_W = $clog2(READ_CELLS + 1);
   localparam int RI_W  = (READ_CELLS > 1) ? $clog2(READ_CELLS) : 1;
   localparam int COL_W = $clog2(GENOME_MAX);
   localparam int CNT_W = $clog2(GENOME_MAX + 1);

   // sweep control
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_SWEEP = 1'b1;

   logic                 state_ff, state_in;
   cfg_type              cfg_ff;
   logic [LEN_W-1:0]     read_count_ff, read_count_in;
   logic                 closed_ff, closed_in;
   logic [CNT_W-1:0]     genome_cnt_ff, genome_cnt_in;
   logic signed [SB-1:0] best_val_ff, best_val_in;
   logic [RI_W-1:0]      best_ri_ff, best_ri_in;
   logic [COL_W-1:0]     best_gi_ff, best_gi_in;
   logic                 launch_ff, launch_in;
   col_type              col_ff, col_in;
   logic [COL_W-1:0]     col_index_ff, col_index_in;
   logic                 col_last_ff, col_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept, load_en, load_room, col_ok, tail_valid;
   logic [LEN_W-1:0]     load_index;

   // chain taps: entry 0 feeds the first cell, entry i+1 is cell i's output
   logic                 tok_valid [READ_CELLS+1];
   logic signed [SB-1:0] tok_up_d  [READ_CELLS+1];
   logic signed [SB-1:0] tok_up_n  [READ_CELLS+1];
   logic signed [SB-1:0] tok_dg_d  [READ_CELLS+1];
   logic signed [SB-1:0] tok_dg_n  [READ_CELLS+1];
   logic signed [SB-1:0] tok_dg_w  [READ_CELLS+1];
   logic signed [SB-1:0] tok_bval  [READ_CELLS+1];
   logic [RI_W-1:0]      tok_bri   [READ_CELLS+1];
   logic [COL_W-1:0]     tok_bgi   [READ_CELLS+1];

   assign busy       = (state_ff == ST_SWEEP);
   assign accept     = start && !busy;
   assign load_index = closed_ff ? '0 : read_count_ff;
   assign load_room  = (load_index < LEN_W'(READ_CELLS));
   assign load_en    = accept && (req_data.action == ACT_LOAD) && load_room;
   assign col_ok     = (genome_cnt_ff < CNT_W'(GENOME_MAX));
   assign tail_valid = tok_valid[READ_CELLS];

   // row above the read: 0 / -north open / -west open; best enters from the window
   assign tok_valid[0] = launch_ff;
   assign tok_up_d[0]  = '0;
   assign tok_up_n[0]  = SB'(0) - SB'(cfg_ff.north_gap_open);
   assign tok_dg_d[0]  = '0;
   assign tok_dg_n[0]  = SB'(0) - SB'(cfg_ff.north_gap_open);
   assign tok_dg_w[0]  = SB'(0) - SB'(cfg_ff.west_gap_open);
   assign tok_bval[0]  = best_val_ff;
   assign tok_bri[0]   = best_ri_ff;
   assign tok_bgi[0]   = best_gi_ff;

   for (genvar i = 0; i < READ_CELLS; i++) begin : g_cell
      agas_cell #(
         .INDEX      (i),
         .READ_CELLS (READ_CELLS),
         .GENOME_MAX (GENOME_MAX),
         .SCORE_BITS (SCORE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cfg          (cfg_ff),
         .col          (col_ff),
         .col_index    (col_index_ff),
         .read_count   (read_count_ff),
         .load_en      (load_en),
         .load_index   (load_index),
         .load_base    (req_data.base),
         .in_valid     (tok_valid[i]),
         .in_up_d      (tok_up_d[i]),
         .in_up_n      (tok_up_n[i]),
         .in_dg_d      (tok_dg_d[i]),
         .in_dg_n      (tok_dg_n[i]),
         .in_dg_w      (tok_dg_w[i]),
         .in_best_val  (tok_bval[i]),
         .in_best_ri   (tok_bri[i]),
         .in_best_gi   (tok_bgi[i]),
         .out_valid    (tok_valid[i+1]),
         .out_up_d     (tok_up_d[i+1]),
         .out_up_n     (tok_up_n[i+1]),
         .out_dg_d     (tok_dg_d[i+1]),
         .out_dg_n     (tok_dg_n[i+1]),
         .out_dg_w     (tok_dg_w[i+1]),
         .out_best_val (tok_bval[i+1]),
         .out_best_ri  (tok_bri[i+1]),
         .out_best_gi  (tok_bgi[i+1])
      );
   end

   // window control
   always_comb begin
      state_in      = state_ff;
      read_count_in = read_count_ff;
      closed_in     = closed_ff;
      genome_cnt_in = genome_cnt_ff;
      best_val_in   = best_val_ff;
      best_ri_in    = best_ri_ff;
      best_gi_in    = best_gi_ff;
      launch_in     = 1'b0;
      col_in        = col_ff;
      col_index_in  = col_index_ff;
      col_last_in   = col_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_LOAD) begin
                  // a load after a closed read starts a new one; window is dropped
                  read_count_in = load_room ? (load_index + LEN_W'(1)) : load_index;
                  closed_in     = req_data.last;
                  genome_cnt_in = '0;
                  best_val_in   = '0;
                  best_ri_in    = '0;
                  best_gi_in    = '0;
               end else if (col_ok) begin
                  col_in.base   = req_data.base;
                  col_in.first  = (genome_cnt_ff == '0);
                  col_index_in  = genome_cnt_ff[COL_W-1:0];
                  col_last_in   = req_data.last;
                  genome_cnt_in = genome_cnt_ff + CNT_W'(1);
                  launch_in     = 1'b1;
                  state_in      = ST_SWEEP;
               end else if (req_data.last) begin
                  // window overran: report what was found and close it
                  rsp_valid_in        = 1'b1;
                  rsp_in.best_score   = 24'(best_val_ff);
                  rsp_in.read_end     = 7'(best_ri_ff);
                  rsp_in.genome_end   = 16'(best_gi_ff);
                  genome_cnt_in       = '0;
                  best_val_in         = '0;
                  best_ri_in          = '0;
                  best_gi_in          = '0;
               end
            end
         end
         ST_SWEEP: begin
            if (tail_valid) begin
               state_in    = ST_IDLE;
               best_val_in = tok_bval[READ_CELLS];
               best_ri_in  = tok_bri[READ_CELLS];
               best_gi_in  = tok_bgi[READ_CELLS];
               if (col_last_ff) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.best_score = 24'(tok_bval[READ_CELLS]);
                  rsp_in.read_end   = 7'(tok_bri[READ_CELLS]);
                  rsp_in.genome_end = 16'(tok_bgi[READ_CELLS]);
                  genome_cnt_in     = '0;
                  best_val_in       = '0;
                  best_ri_in        = '0;
                  best_gi_in        = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_count_ff <= '0;
         closed_ff     <= 1'b0;
         genome_cnt_ff <= '0;
         best_val_ff   <= '0;
         best_ri_ff    <= '0;
         best_gi_ff    <= '0;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_count_ff <= read_count_in;
         closed_ff     <= closed_in;
         genome_cnt_ff <= genome_cnt_in;
         best_val_ff   <= best_val_in;
         best_ri_ff    <= best_ri_in;
         best_gi_ff    <= best_gi_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      col_index_ff <= col_index_in;
      col_last_ff  <= col_last_in;
      rsp_ff       <= rsp_in;
   end

   // scoring registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATCH:      cfg_ff.match_score      <= csr_wdata[7:0];
            CSR_MISMATCH:   cfg_ff.mismatch_score   <= $signed(csr_wdata);
            CSR_WEST_OPEN:  cfg_ff.west_gap_open    <= csr_wdata[7:0];
            CSR_WEST_EXT:   cfg_ff.west_gap_extend  <= csr_wdata[7:0];
            CSR_NORTH_OPEN: cfg_ff.north_gap_open   <= csr_wdata[7:0];
            CSR_NORTH_EXT:  cfg_ff.north_gap_extend <= csr_wdata[7:0];
            CSR_LOCAL_MODE: cfg_ff.local_mode       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // only the launch register and the cell taps can hold the column token
   logic [READ_CELLS:0] tok_valid_vec;
   for (genvar k = 0; k <= READ_CELLS; k++) begin : g_vld
      assign tok_valid_vec[k] = tok_valid[k];
   end

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one column token in the cell row");

   a_tail_in_sweep: assert property (@(posedge clock) disable iff (reset)
      tail_valid |-> (state_ff == ST_SWEEP))
      else $error("column token left the row outside a sweep");

   a_sweep_launch: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && ($past(state_ff) == ST_IDLE)) |-> launch_ff)
      else $error("sweep entered without a launched token");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result beat while a sweep is running");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      read_count_ff <= LEN_W'(READ_CELLS))
      else $error("read length beyond the cell row");

endmodule
